// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the int_vector_matrix_multiply RTL. Every check is
// clocked on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/ivmm_pkg.sv -----
// ----------------------------------------------------------------------------
// ivmm_pkg
// Types, codes and helper functions for the integer vector-matrix multiplier.
// ----------------------------------------------------------------------------
package ivmm_pkg;

  // Default sizes of the vector and matrix stores.
  localparam int ROWS_MAX_DEF = 64;
  localparam int COLS_MAX_DEF = 64;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Reset value of both count registers.
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_VEC = 2'd0,
    CMD_LOAD_MAT = 2'd1,
    CMD_COMPUTE  = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_USED = 1'b0,
    CFG_COLS_USED = 1'b1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [IDX_W-1:0]         column;
    logic signed [DATA_W-1:0] sum;
    logic                     last;
  } out_item_t;

  // Control that travels with each store read into the MAC unit.
  typedef struct packed {
    logic             valid;
    logic             first_row;
    logic             last_row;
    logic             last_col;
    logic [IDX_W-1:0] column;
  } mac_ctl_t;

  // Limit a count register to the range 1..top.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v, input int top);
    logic [CNT_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (int'(v) > top) begin
      res = CNT_W'(top);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/ivmm_ram.sv -----
// ----------------------------------------------------------------------------
// ivmm_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ivmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ivmm_mac.sv -----
// ----------------------------------------------------------------------------
// ivmm_mac
// Shared multiply-accumulate unit. Takes one vector and one matrix element
// per cycle, multiplies them, and accumulates one column sum at a time.
// ----------------------------------------------------------------------------
module ivmm_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ivmm_pkg::mac_ctl_t                    ctl,
  input  logic [ivmm_pkg::DATA_W-1:0]           vec_data,
  input  logic [ivmm_pkg::DATA_W-1:0]           mat_data,
  output logic                                  out_strobe,
  output ivmm_pkg::out_item_t                   out_item
);
  import ivmm_pkg::*;

  mac_ctl_t          ctl1_r, ctl2_r;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              strobe_r;
  out_item_t         item_r;

  // Control passes through ctl1_r and then ctl2_r, so that it lines up with the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
    end
  end

  // Product keeps the low 32 bits, which is the same for signed operands.
  assign prod_nxt = vec_data * mat_data;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Accumulate; the first row of a column starts a fresh sum.
  assign acc_nxt = (ctl2_r.first_row ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (ctl2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register: a column is done on its last row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl2_r.valid && ctl2_r.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl2_r.valid && ctl2_r.last_row) begin
      item_r.column <= ctl2_r.column;
      item_r.sum    <= acc_nxt;
      item_r.last   <= ctl2_r.last_col;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ----- rtl/core/int_vector_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// int_vector_matrix_multiply
// Integer row-vector times matrix product with internal vector and matrix
// stores and one shared multiply-accumulate unit.
//
//   Channel   Handshake            Payload      Notes
//   input     start / busy         in_item      accepted when start && !busy
//   result    out_strobe           out_item     one-cycle strobe per item, no stall
//   config    cfg_we               cfg_index,   written on any cycle with
//                                  cfg_data     cfg_we high
//
// A load item is written to its store on acceptance and leaves busy low.
// A compute item keeps busy high while the MAC unit consumes one store pair
// per cycle, column by column, behind a three-stage pipeline, and until the
// last result has left. Results leave one per column, in column order.
// Reset clears the sequencer and sets the count registers to 64; the stores
// are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module int_vector_matrix_multiply #(
  parameter int ROWS_MAX = ivmm_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = ivmm_pkg::COLS_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ivmm_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output ivmm_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [ivmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ivmm_pkg::CNT_W-1:0]          cfg_data
);
  import ivmm_pkg::*;

  localparam int ROW_AW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int COL_AW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int MAT_DEPTH = ROWS_MAX * (2 ** COL_AW);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  rows_used_r, cols_used_r;
  logic [CNT_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [CNT_W-1:0]  nr_r, nr_nxt, nc_r, nc_nxt;
  logic              accept;
  logic              is_compute;
  logic              last_row, last_col;
  logic              vec_we, mat_we;
  logic [DATA_W-1:0] vec_rdata, mat_rdata;
  mac_ctl_t          issue;

  assign accept     = start && !busy;
  assign is_compute = (in_item.command == CMD_COMPUTE);
  assign last_row   = (row_r + CNT_W'(1)) == nr_r;
  assign last_col   = (col_r + CNT_W'(1)) == nc_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= CNT_RESET;
      cols_used_r <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_USED: rows_used_r <= cfg_data;
        CFG_COLS_USED: cols_used_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store write enables for load items; out-of-range indexes are dropped.
  always_comb begin
    vec_we = 1'b0;
    mat_we = 1'b0;
    if (accept) begin
      unique case (cmd_t'(in_item.command))
        CMD_LOAD_VEC: vec_we = int'(in_item.row_index) < ROWS_MAX;
        CMD_LOAD_MAT: mat_we = (int'(in_item.row_index) < ROWS_MAX) &&
                               (int'(in_item.col_index) < COLS_MAX);
        CMD_COMPUTE:  ;
        CMD_NONE:     ;
        default:      ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && is_compute) state_nxt = ST_RUN;
      ST_RUN:   if (last_row && last_col) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_strobe && out_item.last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: busy flag and the store read issued this cycle.
  always_comb begin
    busy            = (state_r != ST_IDLE);
    issue.valid     = (state_r == ST_RUN);
    issue.first_row = (row_r == '0);
    issue.last_row  = last_row;
    issue.last_col  = last_col;
    issue.column    = IDX_W'(col_r);
  end

  // Row and column walk; counts are latched when a compute starts.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    nr_nxt  = nr_r;
    nc_nxt  = nc_r;
    if (accept && is_compute) begin
      row_nxt = '0;
      col_nxt = '0;
      nr_nxt  = clamp_count(rows_used_r, ROWS_MAX);
      nc_nxt  = clamp_count(cols_used_r, COLS_MAX);
    end else if (state_r == ST_RUN) begin
      if (last_row) begin
        row_nxt = '0;
        col_nxt = col_r + CNT_W'(1);
      end else begin
        row_nxt = row_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      nr_r  <= CNT_W'(1);
      nc_r  <= CNT_W'(1);
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      nr_r  <= nr_nxt;
      nc_r  <= nc_nxt;
    end
  end

  // Vector store.
  ivmm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS_MAX)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (ROW_AW'(in_item.row_index)),
    .wdata (in_item.value),
    .raddr (ROW_AW'(row_r)),
    .rdata (vec_rdata)
  );

  // Matrix store, addressed by row and column.
  ivmm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAT_DEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr ({ROW_AW'(in_item.row_index), COL_AW'(in_item.col_index)}),
    .wdata (in_item.value),
    .raddr ({ROW_AW'(row_r), COL_AW'(col_r)}),
    .rdata (mat_rdata)
  );

  // Shared multiply-accumulate unit.
  ivmm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (issue),
    .vec_data   (vec_rdata),
    .mat_data   (mat_rdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Checks on the sequencer and result flow.
  `ASSERT_SAME(a_result_only_busy, out_strobe, busy)
  `ASSERT_NEXT(a_compute_goes_busy, start && !busy && is_compute, busy)
  `ASSERT_NEXT(a_last_ends_compute, out_strobe && out_item.last, !busy)
  `ASSERT_SAME(a_no_result_in_idle, state_r == ST_IDLE, !out_strobe)

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Vector-matrix product testbench
// Drives load, compute and ignored items into int_vector_matrix_multiply and
// checks every result item against a golden sum or a predicted product. Each
// compute first gets loads for any store entry in the active region that has
// not been written yet. A short directed plan is run first. Random segments
// follow, each with its own row and column counts, under three sender idling
// profiles.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ivmm_pkg::*;

  // Kinds of directed plan steps.
  typedef enum logic {
    STEP_ITEM,
    STEP_CFG
  } step_kind_t;

  // One row of the directed plan.
  typedef struct packed {
    step_kind_t        kind;
    cfg_idx_t          reg_idx;
    logic [CNT_W-1:0]  reg_val;
    in_item_t          item;
    logic              golden_en;
    logic [DATA_W-1:0] golden;
  } plan_step_t;

  localparam int SEG_ITEMS  = 16;
  localparam int SEGS       = 3;
  localparam int IDLE_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  // Predictor state: stores, write flags and count registers.
  logic [DATA_W-1:0] vec_mem [ROWS_MAX_DEF];
  logic [DATA_W-1:0] mat_mem [ROWS_MAX_DEF][COLS_MAX_DEF];
  bit                vec_set [ROWS_MAX_DEF];
  bit                mat_set [ROWS_MAX_DEF][COLS_MAX_DEF];
  logic [CNT_W-1:0]  rows_reg = CNT_RESET;
  logic [CNT_W-1:0]  cols_reg = CNT_RESET;

  out_item_t pending_results [$];
  int        idle_pct = 0;
  int        error_count = 0;
  int        items_sent = 0;
  int        products_sent = 0;
  int        results_checked = 0;

  int_vector_matrix_multiply u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns MISMATCH: %s", $time, what);
  endtask

  // A count of zero acts as one; counts above the store size act as the size.
  function automatic int active_count(input logic [CNT_W-1:0] v, input int top);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > top) begin
      return top;
    end
    return int'(v);
  endfunction

  // Expected column sums for a compute, with wrapping 32-bit products and sums.
  task automatic predict_product();
    int                nr;
    int                nc;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] prod;
    out_item_t         res;
    nr = active_count(rows_reg, ROWS_MAX_DEF);
    nc = active_count(cols_reg, COLS_MAX_DEF);
    for (int c = 0; c < nc; c++) begin
      acc = '0;
      for (int r = 0; r < nr; r++) begin
        prod = vec_mem[r] * mat_mem[r][c];
        acc = acc + prod;
      end
      res.column = IDX_W'(c);
      res.sum = acc;
      res.last = (c == nc - 1);
      pending_results.push_back(res);
    end
  endtask

  // Update the predictor with an item the block has just accepted.
  task automatic absorb_item(input in_item_t it, input bit golden_en,
                             input logic [DATA_W-1:0] golden);
    out_item_t res;
    case (it.command)
      CMD_LOAD_VEC: begin
        vec_mem[it.row_index] = it.value;
        vec_set[it.row_index] = 1'b1;
      end
      CMD_LOAD_MAT: begin
        mat_mem[it.row_index][it.col_index] = it.value;
        mat_set[it.row_index][it.col_index] = 1'b1;
      end
      CMD_COMPUTE: begin
        products_sent++;
        if (golden_en) begin
          res.column = '0;
          res.sum = golden;
          res.last = 1'b1;
          pending_results.push_back(res);
        end else begin
          predict_product();
        end
      end
      default: begin
      end
    endcase
  endtask

  // Present one item from a falling edge and hold it until start && !busy.
  task automatic send_item(input in_item_t it, input bit golden_en,
                           input logic [DATA_W-1:0] golden);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    absorb_item(it, golden_en, golden);
    if (it.command != CMD_NONE) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // Load every unwritten entry that the next compute would read.
  task automatic fill_unwritten();
    in_item_t it;
    int       nr;
    int       nc;
    nr = active_count(rows_reg, ROWS_MAX_DEF);
    nc = active_count(cols_reg, COLS_MAX_DEF);
    for (int r = 0; r < nr; r++) begin
      if (!vec_set[r]) begin
        it = '{command: CMD_LOAD_VEC, row_index: IDX_W'(r), col_index: '0,
               value: $urandom};
        send_item(it, 1'b0, '0);
      end
      for (int c = 0; c < nc; c++) begin
        if (!mat_set[r][c]) begin
          it = '{command: CMD_LOAD_MAT, row_index: IDX_W'(r), col_index: IDX_W'(c),
                 value: $urandom};
          send_item(it, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic issue_item(input in_item_t it, input bit golden_en,
                            input logic [DATA_W-1:0] golden);
    if (it.command == CMD_COMPUTE) begin
      fill_unwritten();
    end
    send_item(it, golden_en, golden);
  endtask

  // Count registers change only with no result outstanding and the block idle.
  task automatic write_count(input cfg_idx_t idx, input logic [CNT_W-1:0] v);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (IDLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ROWS_USED) begin
      rows_reg = v;
    end else begin
      cols_reg = v;
    end
  endtask

  // Mostly small counts, with the extremes and out-of-range values mixed in.
  function automatic logic [CNT_W-1:0] pick_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return CNT_W'($urandom_range(1, 6));
    end
    if (pick < 85) begin
      case ($urandom_range(3))
        0: return '0;
        1: return CNT_W'(1);
        2: return CNT_RESET;
        default: return '1;
      endcase
    end
    return CNT_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(4))
        0: return '0;
        1: return DATA_W'(1);
        2: return '1;
        3: return 32'h7fff_ffff;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Random item: loads mostly land in the active region, computes are common.
  function automatic in_item_t pick_item();
    in_item_t it;
    int       pick;
    int       nr;
    int       nc;
    nr = active_count(rows_reg, ROWS_MAX_DEF);
    nc = active_count(cols_reg, COLS_MAX_DEF);
    pick = $urandom_range(99);
    it.value = pick_value();
    if ($urandom_range(99) < 75) begin
      it.row_index = IDX_W'($urandom_range(0, nr - 1));
      it.col_index = IDX_W'($urandom_range(0, nc - 1));
    end else begin
      it.row_index = IDX_W'($urandom_range(0, 63));
      it.col_index = IDX_W'($urandom_range(0, 63));
    end
    if (pick < 40) begin
      it.command = CMD_LOAD_VEC;
    end else if (pick < 80) begin
      it.command = CMD_LOAD_MAT;
    end else if (pick < 93) begin
      it.command = CMD_COMPUTE;
    end else begin
      it.command = CMD_NONE;
    end
    return it;
  endfunction

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result for column %0d with nothing expected",
                                  out_item.column));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_item.column !== want.column) begin
          report_mismatch($sformatf("column %0d, expected %0d",
                                    out_item.column, want.column));
        end
        if (out_item.sum !== want.sum) begin
          report_mismatch($sformatf("column %0d sum %h, expected %h",
                                    want.column, out_item.sum, want.sum));
        end
        if (out_item.last !== want.last) begin
          report_mismatch($sformatf("column %0d last %b, expected %b",
                                    want.column, out_item.last, want.last));
        end
      end
    end
  end

  // Stimulus: reset, directed plan, then three idling phases of random segments.
  initial begin
    plan_step_t       plan [$];
    plan_step_t       step;
    in_item_t         it;
    int               idle_profile [3];
    int               seg_count;
    logic [CNT_W-1:0] rows_pick;
    logic [CNT_W-1:0] cols_pick;

    idle_profile[0] = 27;
    idle_profile[1] = 86;
    idle_profile[2] = 0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Row count left at its reset value, over a single column.
    step = '0;
    step.kind = STEP_CFG;
    step.reg_idx = CFG_COLS_USED;
    step.reg_val = CNT_W'(1);
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item.command = CMD_COMPUTE;
    plan.push_back(step);

    // Directed plan. Golden sums use one row and one column.
    step = '0;
    step.kind = STEP_CFG;
    step.reg_idx = CFG_ROWS_USED;
    step.reg_val = CNT_W'(1);
    plan.push_back(step);
    step.reg_idx = CFG_COLS_USED;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item = '{command: CMD_LOAD_VEC, row_index: '0, col_index: '0, value: 32'sd3};
    plan.push_back(step);
    step.item = '{command: CMD_LOAD_MAT, row_index: '0, col_index: '0, value: -32'sd5};
    plan.push_back(step);
    step.item = '{command: CMD_COMPUTE, row_index: '0, col_index: '0, value: '0};
    step.golden_en = 1'b1;
    step.golden = -32'sd15;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item = '{command: CMD_LOAD_VEC, row_index: '0, col_index: '0,
                  value: 32'h7fff_ffff};
    plan.push_back(step);
    step.item.command = CMD_LOAD_MAT;
    plan.push_back(step);
    // Largest positive squared leaves one in the low word.
    step.item = '{command: CMD_COMPUTE, row_index: '0, col_index: '0, value: '0};
    step.golden_en = 1'b1;
    step.golden = 32'd1;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item = '{command: CMD_LOAD_VEC, row_index: '0, col_index: '0,
                  value: 32'h8000_0000};
    plan.push_back(step);
    step.item.command = CMD_LOAD_MAT;
    plan.push_back(step);
    // The unused command must not touch the stores.
    step.item = '{command: CMD_NONE, row_index: '0, col_index: '0, value: 32'd7};
    plan.push_back(step);
    step.item = '{command: CMD_COMPUTE, row_index: '0, col_index: '0, value: '0};
    step.golden_en = 1'b1;
    step.golden = '0;
    plan.push_back(step);
    // Zero counts behave as one.
    step = '0;
    step.kind = STEP_CFG;
    step.reg_idx = CFG_ROWS_USED;
    plan.push_back(step);
    step.reg_idx = CFG_COLS_USED;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item = '{command: CMD_LOAD_VEC, row_index: '1, col_index: '1, value: '1};
    plan.push_back(step);
    step.item.command = CMD_LOAD_MAT;
    plan.push_back(step);
    step.item = '{command: CMD_LOAD_MAT, row_index: '0, col_index: '0, value: '1};
    plan.push_back(step);
    step.item = '{command: CMD_COMPUTE, row_index: '0, col_index: '0, value: '0};
    step.golden_en = 1'b1;
    step.golden = 32'h8000_0000;
    plan.push_back(step);
    // Counts above the store size behave as the size, one count at a time.
    step = '0;
    step.kind = STEP_CFG;
    step.reg_idx = CFG_ROWS_USED;
    step.reg_val = '1;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item.command = CMD_COMPUTE;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_CFG;
    step.reg_idx = CFG_ROWS_USED;
    step.reg_val = CNT_W'(1);
    plan.push_back(step);
    step.reg_idx = CFG_COLS_USED;
    step.reg_val = '1;
    plan.push_back(step);
    step = '0;
    step.kind = STEP_ITEM;
    step.item.command = CMD_COMPUTE;
    plan.push_back(step);

    idle_pct = idle_profile[0];
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        write_count(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue_item(plan[i].item, plan[i].golden_en, plan[i].golden);
      end
    end

    // Random segments, each starting from a fresh pair of counts.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = idle_profile[phase];
      for (int seg = 0; seg < SEGS; seg++) begin
        rows_pick = pick_count();
        cols_pick = pick_count();
        // A large count is paired with a single row or column, which the
        // directed plan has already loaded.
        if (active_count(rows_pick, ROWS_MAX_DEF) > 6) begin
          cols_pick = CNT_W'(1);
        end else if (active_count(cols_pick, COLS_MAX_DEF) > 6) begin
          rows_pick = CNT_W'(1);
        end
        write_count(CFG_ROWS_USED, rows_pick);
        write_count(CFG_COLS_USED, cols_pick);
        seg_count = 0;
        while (seg_count < SEG_ITEMS) begin
          it = pick_item();
          issue_item(it, 1'b0, '0);
          if (it.command != CMD_NONE) begin
            seg_count++;
          end
        end
      end
    end
    start = 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d load and compute items, %0d of them products.",
             items_sent, products_sent);
    $display("Checked %0d result items; %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("Timeout with %0d result items outstanding.", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
